/* rtl/fir_af_pkg.sv */
// Shared types and constants of the FIR audio filter.
package fir_af_pkg;

  localparam int SMP_W           = 16;
  localparam int COEF_W          = 16;
  localparam int COEF_IDX_W      = 5;
  localparam int TAP_CNT_W       = 6;
  localparam int PROD_W          = SMP_W + COEF_W;
  localparam int COEFF_FRAC_BITS = 14;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 6'd32;

  // Codes of the request type flag.
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Saturation limits of the 16-bit result.
  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_coef;
    logic load_sample;
    logic issue;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic tap_last;
    logic taps_zero;
    logic out_free;
  } sts_t;

endpackage

/* rtl/fir_af_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module fir_af_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fir_af_datapath.sv */
// Datapath of the FIR filter: coefficient and history memories, MAC pipeline, output register.
module fir_af_datapath #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_wr_en,
  input  logic [fir_af_pkg::TAP_CNT_W-1:0]            cfg_wr_data,
  input  logic [fir_af_pkg::COEF_IDX_W-1:0]           coef_idx,
  input  logic signed [fir_af_pkg::COEF_W-1:0]        coef_val,
  input  logic signed [fir_af_pkg::SMP_W-1:0]         smp_val,
  input  logic                                        smp_start,
  input  fir_af_pkg::cmd_t                            cmd,
  output fir_af_pkg::sts_t                            sts,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic signed [fir_af_pkg::SMP_W-1:0]         out_sample,
  output logic                                        out_sat
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int XW    = (AW > fir_af_pkg::COEF_IDX_W) ? AW : fir_af_pkg::COEF_IDX_W;
  localparam int ACC_W = fir_af_pkg::PROD_W + AW + 1;
  localparam int SW    = fir_af_pkg::SMP_W;

  logic [fir_af_pkg::TAP_CNT_W-1:0] tap_count_r;
  logic [CW-1:0]                    taps_eff;
  logic [MAX_TAPS-1:0]              cvalid_r;
  logic [AW-1:0]                    wp_r, wp_nxt;
  logic [AW-1:0]                    rd_ptr_r;
  logic [CW-1:0]                    k_r;
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic                             s1_vld_r, s1_mask_r;
  logic                             s2_vld_r;
  logic signed [fir_af_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]          acc_r;
  logic                             out_tvalid_r;
  logic signed [SW-1:0]             out_sample_r;
  logic                             out_sat_r;

  logic [XW-1:0]                    idx_ext;
  logic                             idx_ok;
  logic                             coef_we;
  logic signed [SW-1:0]             hist_q;
  logic signed [fir_af_pkg::COEF_W-1:0] coef_q;

  logic                             acc_neg;
  logic [ACC_W-1:0]                 mag;
  logic [ACC_W-1:0]                 quo;
  logic                             sat_c;
  logic signed [SW-1:0]             y_c;

  assign taps_eff = (int'(tap_count_r) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count_r);

  assign idx_ext = XW'(coef_idx);
  assign idx_ok  = int'(coef_idx) < MAX_TAPS;
  assign coef_we = cmd.load_coef && idx_ok;

  assign wp_nxt   = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign fill_nxt = smp_start ? CW'(1) :
                    ((fill_r == CW'(MAX_TAPS)) ? fill_r : fill_r + CW'(1));

  fir_af_ram #(
    .WIDTH (fir_af_pkg::SMP_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.load_sample),
    .waddr (wp_nxt),
    .wdata (smp_val),
    .raddr (rd_ptr_r),
    .rdata (hist_q)
  );

  fir_af_ram #(
    .WIDTH (fir_af_pkg::COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (coef_val),
    .raddr (k_r[AW-1:0]),
    .rdata (coef_q)
  );

  // Control registers: config, valid bits, pointers and pipeline tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r  <= fir_af_pkg::TAP_COUNT_RST;
      cvalid_r     <= '0;
      wp_r         <= '0;
      rd_ptr_r     <= '0;
      k_r          <= '0;
      fill_r       <= '0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (coef_we) begin
        cvalid_r[idx_ext[AW-1:0]] <= 1'b1;
      end
      if (cmd.load_sample) begin
        wp_r     <= wp_nxt;
        rd_ptr_r <= wp_nxt;
        k_r      <= '0;
        fill_r   <= fill_nxt;
      end else if (cmd.issue) begin
        // Walk back through the history, newest sample first.
        rd_ptr_r <= (rd_ptr_r == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_r - AW'(1);
        k_r      <= k_r + CW'(1);
      end
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the MAC pipeline and the output word.
  always_ff @(posedge clk) begin
    // Taps past the fill level or never loaded read as zero.
    s1_mask_r <= (k_r < fill_r) && cvalid_r[k_r[AW-1:0]];
    if (s1_mask_r) begin
      prod_r <= hist_q * coef_q;
    end else begin
      prod_r <= '0;
    end
    if (cmd.load_sample) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_sample_r <= y_c;
      out_sat_r    <= sat_c;
    end
  end

  // Scale by the coefficient fraction, truncating toward zero, then clip.
  always_comb begin
    acc_neg = acc_r[ACC_W-1];
    mag     = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    quo     = mag >> fir_af_pkg::COEFF_FRAC_BITS;
    if (acc_neg) begin
      sat_c = quo > ACC_W'(32768);
      y_c   = sat_c ? fir_af_pkg::SMP_MIN : SW'(-quo[SW-1:0]);
    end else begin
      sat_c = quo > ACC_W'(32767);
      y_c   = sat_c ? fir_af_pkg::SMP_MAX : SW'(quo[SW-1:0]);
    end
  end

  assign sts.pipe_busy = s1_vld_r || s2_vld_r;
  assign sts.tap_last  = (k_r + CW'(1)) == taps_eff;
  assign sts.taps_zero = taps_eff == '0;
  assign sts.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_sample = out_sample_r;
  assign out_sat    = out_sat_r;

`ifndef SYNTHESIS
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (k_r < taps_eff))
    else $error("tap issued beyond the taps in use");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_TAPS))
    else $error("history fill level exceeds depth");

  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!s1_vld_r && !s2_vld_r && sts.out_free))
    else $error("result loaded before pipeline drained or slot free");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid_r)
    else $error("loaded result not presented");
`endif

endmodule

/* rtl/fir_af_ctrl.sv */
// Controller state machine of the FIR filter.
module fir_af_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             req_type,
  output logic             in_tready,
  output fir_af_pkg::cmd_t cmd,
  input  fir_af_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt       = state_r;
    cmd.load_coef   = 1'b0;
    cmd.load_sample = 1'b0;
    cmd.issue       = 1'b0;
    cmd.out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == fir_af_pkg::REQ_SAMPLE) begin
            cmd.load_sample = 1'b1;
            state_nxt       = sts.taps_zero ? ST_DRAIN : ST_MAC;
          end else begin
            cmd.load_coef = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // Hold the finished sum until the output slot is free.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(cmd.load_coef || cmd.load_sample))
    else $error("input taken while filter busy");

  a_mac_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_sample && !sts.taps_zero) |=> (state_r == ST_MAC))
    else $error("sample did not start the tap walk");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_coef, cmd.load_sample, cmd.issue, cmd.out_load}))
    else $error("more than one command at once");
`endif

endmodule

/* rtl/fir_audio_filter_core.sv */
// Top level of the direct-form FIR audio filter.
//
// Input words arrive on in_t*: tuser[0] is the request type (0 loads a
// coefficient, 1 is a PCM sample) and tuser[1] marks the start of a stream,
// which clears the sample history before that sample is taken.
// A coefficient load gives no result. A sample walks the taps in use with
// one multiply-accumulate per cycle through the shared multiplier. Once the
// pipeline has drained, the sum is scaled, clipped and loaded into the output
// register on out_t* as soon as that is free; only then is the next word accepted.
// cfg_wr_en / cfg_wr_data write tap_count; write it only while the block idles.
// A value of zero gives zero results, values above MAX_TAPS act as MAX_TAPS.
// Reset clears the history, marks all coefficients as zero and sets tap_count
// to 32; there is no clearing pass.
// If the receiver stalls, the result waits in the output register while the
// next word is still accepted; the next result then waits until it is taken.
module fir_audio_filter_core #(
  parameter int MAX_TAPS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coeff_index[4:0], coeff_value[20:5], sample_value[36:21]
  input  logic [1:0]  in_tuser,   // req_type[0], stream_start[1]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // filtered_sample[15:0]
  output logic        out_tuser,  // saturated[0]
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data // tap_count
);

  fir_af_pkg::cmd_t cmd;
  fir_af_pkg::sts_t sts;
  logic signed [fir_af_pkg::SMP_W-1:0] out_sample;

  fir_af_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser[0]),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fir_af_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .coef_idx    (in_tdata[4:0]),
    .coef_val    (in_tdata[20:5]),
    .smp_val     (in_tdata[36:21]),
    .smp_start   (in_tuser[1]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_sample  (out_sample),
    .out_sat     (out_tuser)
  );

  assign out_tdata = out_sample;

endmodule

/* test/fir_audio_filter_core_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the FIR audio filter core that predicts every filtered word and checks the output stream.
module fir_audio_filter_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // coeff_index[4:0], coeff_value[20:5], sample_value[36:21]
  input  logic [1:0]  in_tuser,   // req_type[0], stream_start[1]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // filtered_sample[15:0]
  input  logic        out_tuser,  // saturated[0]
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data, // tap_count
  output int          outstanding,
  output int          fail_count
);

  localparam int TAPS_MAX = 32;

  typedef struct packed {
    logic signed [fir_af_pkg::SMP_W-1:0] value;
    logic                                clipped;
  } filt_word_t;

  logic signed [fir_af_pkg::SMP_W-1:0]  history [TAPS_MAX];
  logic signed [fir_af_pkg::COEF_W-1:0] coefs   [TAPS_MAX];
  logic [fir_af_pkg::TAP_CNT_W-1:0]     taps = fir_af_pkg::TAP_COUNT_RST;
  filt_word_t                           filt_due_q [$];
  filt_word_t                           want;
  int                                   errors = 0;

  assign fail_count = errors;

  // Shifts one sample into the history line and forms the scaled, clipped sum.
  function automatic filt_word_t filter_next(logic signed [fir_af_pkg::SMP_W-1:0] smp,
                                             logic start);
    longint     acc;
    longint     mag;
    longint     q;
    int         n;
    filt_word_t res;
    if (start) begin
      foreach (history[k]) history[k] = '0;
    end
    for (int k = TAPS_MAX - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = smp;
    n = (taps > TAPS_MAX) ? TAPS_MAX : int'(taps);
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(history[k]) * longint'(coefs[k]);
    // Scaling works on the magnitude so that the result truncates toward zero.
    mag = (acc < 0) ? -acc : acc;
    q = mag >> fir_af_pkg::COEFF_FRAC_BITS;
    res.clipped = 1'b0;
    if (acc < 0) begin
      if (q > 32768) begin
        q = 32768;
        res.clipped = 1'b1;
      end
      res.value = fir_af_pkg::SMP_W'(-q);
    end else begin
      if (q > 32767) begin
        q = 32767;
        res.clipped = 1'b1;
      end
      res.value = fir_af_pkg::SMP_W'(q);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (history[k]) history[k] = '0;
      foreach (coefs[k]) coefs[k] = '0;
      taps = fir_af_pkg::TAP_COUNT_RST;
      filt_due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (filt_due_q.size() == 0) begin
          $display("%0t: unexpected filtered word %0d saturated %0b", $time,
                   $signed(out_tdata), out_tuser);
          errors++;
        end else begin
          want = filt_due_q.pop_front();
          if (out_tdata !== want.value) begin
            $display("%0t: filtered sample expected %0d got %0d", $time,
                     want.value, $signed(out_tdata));
            errors++;
          end
          if (out_tuser !== want.clipped) begin
            $display("%0t: saturated flag expected %0b got %0b", $time,
                     want.clipped, out_tuser);
            errors++;
          end
        end
      end
      if (cfg_wr_en) taps = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == fir_af_pkg::REQ_SAMPLE) begin
          filt_due_q.push_back(filter_next(in_tdata[36:21], in_tuser[1]));
        end else begin
          coefs[in_tdata[4:0]] = in_tdata[20:5];
        end
      end
    end
    outstanding <= filt_due_q.size();
  end

endmodule

/* test/fir_audio_filter_core_test.sv */
`timescale 1ns / 1ps
// Top of the FIR audio filter core testbench: clock, reset, stimulus, flow control and verdict.
module fir_audio_filter_core_test;

  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 45;
  localparam int SEG_WORDS    = 45;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;  // coeff_index[4:0], coeff_value[20:5], sample_value[36:21]
  logic [1:0]  in_tuser    = '0;  // req_type[0], stream_start[1]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // filtered_sample[15:0]
  logic        out_tuser;         // saturated[0]
  logic        cfg_wr_en   = 1'b0;
  logic [5:0]  cfg_wr_data = '0;

  int outstanding;
  int fail_count;
  int send_idle_pct = 8;
  int recv_idle_pct = 83;
  int stall_seq     = 0;
  int stall_seen    = 0;
  int stall_left    = 0;
  int samples_sent  = 0;
  int coefs_sent    = 0;

  int tap_plan [9] = '{0, 63, 1, 33, 7, 32, 2, 20, 32};

  fir_audio_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  fir_audio_filter_core_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random backpressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_seen != stall_seq) begin
      stall_seen <= stall_seq;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Run timed out with %0d words still outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // Extremes, small values and full-range values, with full-range values half the time.
  function automatic logic [15:0] rand_value();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      1:       v = 16'($urandom_range(0, 511)) - 16'd256;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_word(input logic req, input logic [4:0] idx, input logic [15:0] coef,
                           input logic [15:0] smp, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, smp, coef, idx};
    in_tuser  <= {start, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == fir_af_pkg::REQ_SAMPLE) samples_sent++;
    else coefs_sent++;
  endtask

  // A coefficient load gives no result, so allow for work still in flight.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic        req;
    logic [15:0] coef;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // All coefficients are still zero after reset.
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd31, 16'h7FFF, 16'd100, 1'b1);
    // Loads carry junk in the sample fields, which must be ignored.
    send_word(fir_af_pkg::REQ_COEF, 5'd0, 16'h4000, 16'hFFFF, 1'b1);
    send_word(fir_af_pkg::REQ_COEF, 5'd31, 16'h8000, 16'h8000, 1'b0);
    send_word(fir_af_pkg::REQ_COEF, 5'd1, 16'h7FFF, 16'h0000, 1'b1);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'h7FFF, 1'b1);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd31, 16'hFFFF, 16'h8000, 1'b0);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd17, 16'h1234, 16'hFFFF, 1'b0);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd2, 16'h8000, 16'h0001, 1'b0);
    send_word(fir_af_pkg::REQ_COEF, 5'd2, 16'h7FFF, 16'h7FFF, 1'b0);
    send_word(fir_af_pkg::REQ_COEF, 5'd3, 16'h7FFF, 16'h1234, 1'b1);
    // Full-scale runs drive the sum past both ends of the output range.
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'h7FFF, 1'b1);
    repeat (3) send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'h7FFF, 1'b0);
    repeat (4) send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'h8000, 1'b0);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'h0000, 1'b1);
    // A negative sum that is not a multiple of the scale truncates toward zero.
    send_word(fir_af_pkg::REQ_COEF, 5'd0, 16'h2000, 16'h0000, 1'b0);
    send_word(fir_af_pkg::REQ_SAMPLE, 5'd0, 16'h0000, 16'hFFFD, 1'b1);

    foreach (tap_plan[seg]) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= 6'(tap_plan[seg]);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      // The last segment opens with a long output stall so the input backs up.
      if (seg == 8) stall_seq++;
      repeat (SEG_WORDS) begin
        req  = ($urandom_range(3) != 0) ? fir_af_pkg::REQ_SAMPLE : fir_af_pkg::REQ_COEF;
        coef = $signed(rand_value()) >>> $urandom_range(0, 6);
        send_word(req, 5'($urandom), coef, rand_value(), ($urandom_range(19) == 0));
      end
    end

    wait_drained();
    $display("Covered %0d sample words and %0d coefficient loads over %0d tap settings,",
             samples_sent, coefs_sent, $size(tap_plan));
    $display("with idling on both sides, a long output stall and back-to-back traffic.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
